// ----- design/reassembly_admission_accounting_defines.svh -----
// Assertion macros shared by the reassembly accounting RTL
`ifndef REASSEMBLY_ADMISSION_ACCOUNTING_DEFINES_SVH
`define REASSEMBLY_ADMISSION_ACCOUNTING_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset
`define RAA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define RAA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/raa_pkg.sv -----
// Package: commands, verdict codes, register map, reset values and shared types
`default_nettype none

package raa_pkg;

    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_ADMIT  = 2'd2;

    localparam logic [2:0] VERDICT_OK     = 3'd0;
    localparam logic [2:0] VERDICT_FSEGS  = 3'd1;
    localparam logic [2:0] VERDICT_FBYTES = 3'd2;
    localparam logic [2:0] VERDICT_GBYTES = 3'd3;
    localparam logic [2:0] VERDICT_GSEGS  = 3'd4;

    localparam logic [IDX_W-1:0] REG_DEFAULT_MSS      = 3'd0;
    localparam logic [IDX_W-1:0] REG_FLOW_MAX_BYTES   = 3'd1;
    localparam logic [IDX_W-1:0] REG_FLOW_MAX_SEGS    = 3'd2;
    localparam logic [IDX_W-1:0] REG_GLOBAL_MAX_BYTES = 3'd3;
    localparam logic [IDX_W-1:0] REG_GLOBAL_MAX_SEGS  = 3'd4;

    localparam logic [15:0] RST_DEFAULT_MSS      = 16'd1460;
    localparam logic [31:0] RST_FLOW_MAX_BYTES   = 32'd65536;
    localparam logic [15:0] RST_FLOW_MAX_SEGS    = 16'd64;
    localparam logic [31:0] RST_GLOBAL_MAX_BYTES = 32'd1048576;
    localparam logic [31:0] RST_GLOBAL_MAX_SEGS  = 32'd1024;

    typedef struct packed {
        logic [15:0] default_mss;
        logic [31:0] flow_max_bytes;
        logic [15:0] flow_max_segs;
        logic [31:0] global_max_bytes;
        logic [31:0] global_max_segs;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] byte_amount;
        logic [31:0] seg_amount;
        logic [15:0] flow_mss;
        logic [31:0] flow_window_max;
        logic [15:0] flow_queued_segs;
        logic [31:0] flow_ooo_bytes;
        logic [15:0] nodes_after;
    } item_t;

endpackage

`default_nettype wire

// ----- design/raa_regs.sv -----
// APB register file holding the admission limits
`default_nettype none

module raa_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [raa_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output raa_pkg::cfg_t              cfg
);
    import raa_pkg::*;

    logic [15:0]      default_mss_reg;
    logic [31:0]      flow_max_bytes_reg;
    logic [15:0]      flow_max_segs_reg;
    logic [31:0]      global_max_bytes_reg;
    logic [31:0]      global_max_segs_reg;
    logic             wr_en;
    logic [IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_mss_reg      <= RST_DEFAULT_MSS;
            flow_max_bytes_reg   <= RST_FLOW_MAX_BYTES;
            flow_max_segs_reg    <= RST_FLOW_MAX_SEGS;
            global_max_bytes_reg <= RST_GLOBAL_MAX_BYTES;
            global_max_segs_reg  <= RST_GLOBAL_MAX_SEGS;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DEFAULT_MSS:      default_mss_reg      <= pwdata[15:0];
                REG_FLOW_MAX_BYTES:   flow_max_bytes_reg   <= pwdata;
                REG_FLOW_MAX_SEGS:    flow_max_segs_reg    <= pwdata[15:0];
                REG_GLOBAL_MAX_BYTES: global_max_bytes_reg <= pwdata;
                REG_GLOBAL_MAX_SEGS:  global_max_segs_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DEFAULT_MSS:      prdata = {16'd0, default_mss_reg};
            REG_FLOW_MAX_BYTES:   prdata = flow_max_bytes_reg;
            REG_FLOW_MAX_SEGS:    prdata = {16'd0, flow_max_segs_reg};
            REG_GLOBAL_MAX_BYTES: prdata = global_max_bytes_reg;
            REG_GLOBAL_MAX_SEGS:  prdata = global_max_segs_reg;
            default:              prdata = 32'd0;
        endcase
    end

    assign cfg.default_mss      = default_mss_reg;
    assign cfg.flow_max_bytes   = flow_max_bytes_reg;
    assign cfg.flow_max_segs    = flow_max_segs_reg;
    assign cfg.global_max_bytes = global_max_bytes_reg;
    assign cfg.global_max_segs  = global_max_segs_reg;

endmodule

`default_nettype wire

// ----- design/raa_admit.sv -----
// Admission check: per-flow byte limit and prioritized verdict
`default_nettype none

module raa_admit (
    input  raa_pkg::item_t item,
    input  raa_pkg::cfg_t  cfg,
    input  logic [31:0]    byte_total,
    input  logic [31:0]    seg_total,
    output logic [2:0]     verdict
);
    import raa_pkg::*;

    logic [15:0] mss;
    logic [31:0] floor_raw;
    logic [31:0] half_max;
    logic [31:0] floor_cap;
    logic [31:0] limit_half;
    logic [31:0] limit_cap;
    logic [31:0] limit_floor;
    logic [31:0] limit;
    logic [32:0] flow_sum;
    logic [32:0] glob_sum;
    logic [32:0] seg_sum;
    logic        has_bytes;
    logic        seg_inc;
    logic        fail_fsegs;
    logic        fail_fbytes;
    logic        fail_gbytes;
    logic        fail_gsegs;

    always_comb
    begin
        mss         = (item.flow_mss != 16'd0) ? item.flow_mss : cfg.default_mss;
        floor_raw   = {14'd0, mss, 2'b00};
        half_max    = {1'b0, cfg.flow_max_bytes[31:1]};
        floor_cap   = (floor_raw > half_max) ? half_max : floor_raw;
        limit_half  = {1'b0, item.flow_window_max[31:1]};
        limit_cap   = (limit_half > cfg.flow_max_bytes) ? cfg.flow_max_bytes : limit_half;
        limit_floor = (limit_cap < floor_cap) ? floor_cap : limit_cap;
        limit       = (limit_floor > item.flow_window_max) ? item.flow_window_max
                                                           : limit_floor;

        // sums kept at 33 bits so the compares never wrap
        flow_sum = {1'b0, item.flow_ooo_bytes} + {1'b0, item.byte_amount};
        glob_sum = {1'b0, byte_total} + {1'b0, item.byte_amount};
        seg_sum  = {1'b0, seg_total} + 33'd1;

        has_bytes   = (item.byte_amount != 32'd0);
        seg_inc     = (item.nodes_after >= item.flow_queued_segs);
        fail_fsegs  = (item.nodes_after >= cfg.flow_max_segs);
        fail_fbytes = has_bytes && (flow_sum > {1'b0, limit});
        fail_gbytes = has_bytes && (glob_sum > {1'b0, cfg.global_max_bytes});
        fail_gsegs  = seg_inc && (seg_sum > {1'b0, cfg.global_max_segs});

        if (fail_fsegs)
            verdict = VERDICT_FSEGS;
        else if (fail_fbytes)
            verdict = VERDICT_FBYTES;
        else if (fail_gbytes)
            verdict = VERDICT_GBYTES;
        else if (fail_gsegs)
            verdict = VERDICT_GSEGS;
        else
            verdict = VERDICT_OK;
    end

endmodule

`default_nettype wire

// ----- design/reassembly_admission_accounting.sv -----
// Top level: global reassembly byte/segment totals and admission verdicts
//
//  channel   dir  handshake        payload
//  s_*       in   tvalid/tready    tdata: 7 item fields, tuser: command
//  m_*       out  tvalid/tready    tdata: totals, tuser: verdict
//  apb       in   psel/penable     5 registers at 4*i, pready tied high
//
// One item per cycle sustained while m_tready holds. Each item is first held
// in the input register, then its result sits in the output register until taken.
// The totals update as an item moves to the output register, so the next
// item already sees them. A stalled output fills the input register and
// then drops s_tready. rst_n clears totals and valids, reloads limit defaults.
`default_nettype none

`include "reassembly_admission_accounting_defines.svh"

module reassembly_admission_accounting (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [31:0] byte_amount, [63:32] seg_amount, [79:64] flow_mss,
    // [111:80] flow_window_max, [127:112] flow_queued_segs,
    // [159:128] flow_ooo_bytes, [175:160] nodes_after
    input  logic [175:0]               s_tdata,
    // [1:0] command
    input  logic [1:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [31:0] total_bytes, [63:32] total_segs
    output logic [63:0]                m_tdata,
    // [2:0] verdict
    output logic [2:0]                 m_tuser,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [raa_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import raa_pkg::*;

    cfg_t        cfg;
    item_t       in_item;
    item_t       s1_item_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic [2:0]  res_verdict_reg;
    logic [31:0] res_bytes_reg;
    logic [31:0] res_segs_reg;
    logic [31:0] byte_total_reg;
    logic [31:0] byte_total_next;
    logic [31:0] seg_total_reg;
    logic [31:0] seg_total_next;
    logic [2:0]  admit_verdict;
    logic [2:0]  verdict_next;
    logic [32:0] byte_add;
    logic [32:0] seg_add;
    logic        res_free;
    logic        advance;
    logic        in_xfer;

    raa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    raa_admit u_admit (
        .item       (s1_item_reg),
        .cfg        (cfg),
        .byte_total (byte_total_reg),
        .seg_total  (seg_total_reg),
        .verdict    (admit_verdict)
    );

    assign in_item.command          = s_tuser;
    assign in_item.byte_amount      = s_tdata[31:0];
    assign in_item.seg_amount       = s_tdata[63:32];
    assign in_item.flow_mss         = s_tdata[79:64];
    assign in_item.flow_window_max  = s_tdata[111:80];
    assign in_item.flow_queued_segs = s_tdata[127:112];
    assign in_item.flow_ooo_bytes   = s_tdata[159:128];
    assign in_item.nodes_after      = s_tdata[175:160];

    assign res_free = !res_valid_reg || m_tready;
    assign advance  = s1_valid_reg && res_free;
    assign s_tready = !s1_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    assign s1_valid_next  = in_xfer || (s1_valid_reg && !advance);
    assign res_valid_next = advance || (res_valid_reg && !m_tready);

    always_comb
    begin
        byte_add        = {1'b0, byte_total_reg} + {1'b0, s1_item_reg.byte_amount};
        seg_add         = {1'b0, seg_total_reg} + {1'b0, s1_item_reg.seg_amount};
        byte_total_next = byte_total_reg;
        seg_total_next  = seg_total_reg;
        verdict_next    = VERDICT_OK;
        case (s1_item_reg.command)
            CMD_ADD:
            begin
                byte_total_next = byte_add[32] ? 32'hFFFF_FFFF : byte_add[31:0];
                seg_total_next  = seg_add[32] ? 32'hFFFF_FFFF : seg_add[31:0];
            end
            CMD_REMOVE:
            begin
                byte_total_next = (byte_total_reg >= s1_item_reg.byte_amount)
                                ? byte_total_reg - s1_item_reg.byte_amount : 32'd0;
                seg_total_next  = (seg_total_reg >= s1_item_reg.seg_amount)
                                ? seg_total_reg - s1_item_reg.seg_amount : 32'd0;
            end
            CMD_ADMIT:
            begin
                verdict_next = admit_verdict;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            byte_total_reg <= 32'd0;
            seg_total_reg  <= 32'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                byte_total_reg <= byte_total_next;
                seg_total_reg  <= seg_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_item_reg <= in_item;
        if (advance)
        begin
            res_verdict_reg <= verdict_next;
            res_bytes_reg   <= byte_total_next;
            res_segs_reg    <= seg_total_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {res_segs_reg, res_bytes_reg};
    assign m_tuser  = res_verdict_reg;

    `RAA_ASSERT_NEXT(a_result_matches_totals, advance,
        (res_bytes_reg == byte_total_reg) && (res_segs_reg == seg_total_reg),
        "result totals differ from the running totals")
    `RAA_ASSERT_NEXT(a_admit_keeps_totals, advance && (s1_item_reg.command == CMD_ADMIT),
        $stable(byte_total_reg) && $stable(seg_total_reg),
        "admit transfer changed the totals")
    `RAA_ASSERT_NEXT(a_add_no_decrease, advance && (s1_item_reg.command == CMD_ADD),
        (byte_total_reg >= $past(byte_total_reg)) && (seg_total_reg >= $past(seg_total_reg)),
        "add transfer lowered a total")
    `RAA_ASSERT_NEXT(a_remove_no_increase, advance && (s1_item_reg.command == CMD_REMOVE),
        (byte_total_reg <= $past(byte_total_reg)) && (seg_total_reg <= $past(seg_total_reg)),
        "remove transfer raised a total")
    `RAA_ASSERT_NOW(a_verdict_only_on_admit, advance && (s1_item_reg.command != CMD_ADMIT),
        verdict_next == VERDICT_OK,
        "nonzero verdict on a total update")

endmodule

`default_nettype wire

// ----- tb/reassembly_admission_accounting_tb.sv -----
// Self-checking bench: reassembly totals and admission verdicts, stream in/out, APB limits
module reassembly_admission_accounting_tb;
    import raa_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;     // unused code: totals hold, verdict ok
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 156;
    localparam int HOLD_CYCLES = 40;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [31:0] total_bytes;
        logic [31:0] total_segs;
    } outcome_t;

    typedef struct {
        item_t    it;
        bit       typed;
        outcome_t want;
    } row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [175:0]        s_tdata;
    logic [1:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [63:0]         m_tdata;
    logic [2:0]          m_tuser;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // shadow of the limit registers and the running totals
    logic [15:0] cfg_mss;
    logic [31:0] cfg_fbytes;
    logic [15:0] cfg_fsegs;
    logic [31:0] cfg_gbytes;
    logic [31:0] cfg_gsegs;
    logic [31:0] acc_bytes;
    logic [31:0] acc_segs;

    outcome_t expected_outcomes[$];
    int       err_count = 0;
    int       send_pct  = 0;
    int       stall_pct = 0;
    int       hold_req  = 0;

    reassembly_admission_accounting i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < 40)
            $display("ERROR @%0t: %s got %h want %h", $time, what, got, want);
        err_count++;
    endtask

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // per-flow byte ceiling: min(wnd, max(min(wnd/2, flow max), min(4*mss, flow max/2)))
    function automatic logic [31:0] flow_limit(input logic [15:0] flow_mss,
                                               input logic [31:0] wnd);
        logic [31:0] mss;
        logic [31:0] floor_v;
        logic [31:0] lim;
        mss = (flow_mss != 16'd0) ? {16'd0, flow_mss} : {16'd0, cfg_mss};
        floor_v = mss << 2;
        if (floor_v > (cfg_fbytes >> 1))
            floor_v = cfg_fbytes >> 1;
        lim = wnd >> 1;
        if (lim > cfg_fbytes)
            lim = cfg_fbytes;
        if (lim < floor_v)
            lim = floor_v;
        if (lim > wnd)
            lim = wnd;
        return lim;
    endfunction

    function automatic outcome_t predict_outcome(input item_t it);
        outcome_t o;
        logic [32:0] sum;
        o.verdict = VERDICT_OK;
        case (it.command)
            CMD_ADD:
            begin
                acc_bytes = sat_add(acc_bytes, it.byte_amount);
                acc_segs  = sat_add(acc_segs, it.seg_amount);
            end
            CMD_REMOVE:
            begin
                acc_bytes = (acc_bytes >= it.byte_amount) ? acc_bytes - it.byte_amount : 32'd0;
                acc_segs  = (acc_segs >= it.seg_amount) ? acc_segs - it.seg_amount : 32'd0;
            end
            CMD_ADMIT:
            begin
                sum = {1'b0, it.flow_ooo_bytes} + {1'b0, it.byte_amount};
                if (it.nodes_after >= cfg_fsegs)
                    o.verdict = VERDICT_FSEGS;
                else if (it.byte_amount != 32'd0 &&
                         sum > {1'b0, flow_limit(it.flow_mss, it.flow_window_max)})
                    o.verdict = VERDICT_FBYTES;
                else if (it.byte_amount != 32'd0 &&
                         ({1'b0, acc_bytes} + {1'b0, it.byte_amount}) > {1'b0, cfg_gbytes})
                    o.verdict = VERDICT_GBYTES;
                else if (it.nodes_after >= it.flow_queued_segs &&
                         ({1'b0, acc_segs} + 33'd1) > {1'b0, cfg_gsegs})
                    o.verdict = VERDICT_GSEGS;
            end
            default: ;
        endcase
        o.total_bytes = acc_bytes;
        o.total_segs  = acc_segs;
        return o;
    endfunction

    // random, small, near-all-ones and scaled values, now and then something close to a boundary
    function automatic logic [31:0] pick_word(input logic [31:0] near);
        logic [31:0] w;
        case ($urandom_range(0, 5))
            0:       w = $urandom;
            1:       w = $urandom_range(0, 16);
            2:       w = 32'hFFFF_FFFF - $urandom_range(0, 16);
            3:       w = near + $urandom_range(0, 8) - 32'd4;
            4:       w = $urandom_range(0, 4000);
            default: w = $urandom >> $urandom_range(0, 31);
        endcase
        return w;
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int r;
        logic [31:0] w;
        r = $urandom_range(0, 99);
        it.command = (r < 30) ? CMD_ADD : (r < 55) ? CMD_REMOVE : (r < 95) ? CMD_ADMIT : CMD_NOP;
        it.byte_amount      = $urandom;
        it.seg_amount       = $urandom;
        it.flow_mss         = 16'($urandom);
        it.flow_window_max  = $urandom;
        it.flow_queued_segs = 16'($urandom);
        it.flow_ooo_bytes   = $urandom;
        it.nodes_after      = 16'($urandom);
        if (it.command == CMD_ADD)
        begin
            it.byte_amount = pick_word(cfg_gbytes - acc_bytes);
            it.seg_amount  = pick_word(cfg_gsegs - acc_segs);
        end
        else if (it.command == CMD_REMOVE)
        begin
            it.byte_amount = pick_word(acc_bytes);
            it.seg_amount  = pick_word(acc_segs);
        end
        else if (it.command == CMD_ADMIT)
        begin
            // half the checks pass a nonzero node limit so byte and global checks see traffic
            if ($urandom_range(0, 1) == 1 && cfg_fsegs != 16'd0)
                it.nodes_after = 16'($urandom_range(0, cfg_fsegs - 16'd1));
            else
            begin
                w = pick_word({16'd0, cfg_fsegs});
                it.nodes_after = w[15:0];
            end
            w = pick_word({16'd0, it.nodes_after});
            it.flow_queued_segs = w[15:0];
            w = pick_word(32'd0);
            it.flow_mss = w[15:0];
            it.flow_window_max = pick_word(cfg_fbytes << 1);
            it.byte_amount = pick_word(cfg_gbytes - acc_bytes);
            it.flow_ooo_bytes = pick_word(flow_limit(it.flow_mss, it.flow_window_max)
                                          - it.byte_amount);
        end
        return it;
    endfunction

    function automatic row_t mk_row(input logic [1:0] cmd, input logic [31:0] bytes,
                                    input logic [31:0] segs, input logic [15:0] mss,
                                    input logic [31:0] wnd, input logic [15:0] queued,
                                    input logic [31:0] used, input logic [15:0] nodes,
                                    input bit typed, input logic [2:0] verdict,
                                    input logic [31:0] tb, input logic [31:0] ts);
        row_t r;
        r.it.command          = cmd;
        r.it.byte_amount      = bytes;
        r.it.seg_amount       = segs;
        r.it.flow_mss         = mss;
        r.it.flow_window_max  = wnd;
        r.it.flow_queued_segs = queued;
        r.it.flow_ooo_bytes   = used;
        r.it.nodes_after      = nodes;
        r.typed               = typed;
        r.want.verdict        = verdict;
        r.want.total_bytes    = tb;
        r.want.total_segs     = ts;
        return r;
    endfunction

    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DEFAULT_MSS:      cfg_mss    = data[15:0];
            REG_FLOW_MAX_BYTES:   cfg_fbytes = data;
            REG_FLOW_MAX_SEGS:    cfg_fsegs  = data[15:0];
            REG_GLOBAL_MAX_BYTES: cfg_gbytes = data;
            REG_GLOBAL_MAX_SEGS:  cfg_gsegs  = data;
            default: ;
        endcase
    endtask

    task automatic load_limits(input logic [15:0] mss, input logic [31:0] fbytes,
                               input logic [15:0] fsegs, input logic [31:0] gbytes,
                               input logic [31:0] gsegs);
        apb_write(REG_DEFAULT_MSS, {16'd0, mss});
        apb_write(REG_FLOW_MAX_BYTES, fbytes);
        apb_write(REG_FLOW_MAX_SEGS, {16'd0, fsegs});
        apb_write(REG_GLOBAL_MAX_BYTES, gbytes);
        apb_write(REG_GLOBAL_MAX_SEGS, gsegs);
    endtask

    // offer one transfer; the expectation is queued at the accepting edge
    task automatic offer(input item_t it, input bit typed, input outcome_t given);
        outcome_t o;
        while ($urandom_range(0, 99) < send_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.command;
        s_tdata  <= {it.nodes_after, it.flow_ooo_bytes, it.flow_queued_segs,
                     it.flow_window_max, it.flow_mss, it.seg_amount, it.byte_amount};
        do @(posedge clk); while (!s_tready);
        o = predict_outcome(it);
        expected_outcomes.push_back(typed ? given : o);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // receive side: check, then decide tready for the next edge
    initial
    begin
        outcome_t want;
        int hold_done;
        int hold_left;
        hold_done = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (expected_outcomes.size() == 0)
                    report_mismatch("result with nothing pending", m_tdata[31:0], 32'd0);
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (m_tuser !== want.verdict)
                        report_mismatch("verdict", {29'd0, m_tuser}, {29'd0, want.verdict});
                    if (m_tdata[31:0] !== want.total_bytes)
                        report_mismatch("total_bytes", m_tdata[31:0], want.total_bytes);
                    if (m_tdata[63:32] !== want.total_segs)
                        report_mismatch("total_segs", m_tdata[63:32], want.total_segs);
                end
            end
            if (hold_done != hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = hold_req;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        row_t     dir_tab[$];
        outcome_t none;
        int       p;
        int       n;
        none     = '0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_ADD;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cfg_mss    = RST_DEFAULT_MSS;
        cfg_fbytes = RST_FLOW_MAX_BYTES;
        cfg_fsegs  = RST_FLOW_MAX_SEGS;
        cfg_gbytes = RST_GLOBAL_MAX_BYTES;
        cfg_gsegs  = RST_GLOBAL_MAX_SEGS;
        acc_bytes  = 32'd0;
        acc_segs   = 32'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, run with the reset limits
        //                     cmd  bytes  segs  mss  wnd  queued used  nodes
        dir_tab.push_back(mk_row(CMD_ADMIT, 0, 0, 0, 0, 0, 0, 0,
                                 1, VERDICT_OK, 0, 0));
        dir_tab.push_back(mk_row(CMD_ADMIT, 0, 0, 0, 0, 0, 0, 64,
                                 1, VERDICT_FSEGS, 0, 0));
        // node limit wins over a byte failure
        dir_tab.push_back(mk_row(CMD_ADMIT, 32'hFFFF_FFFF, 0, 0, 0, 16'hFFFF, 0, 16'hFFFF,
                                 1, VERDICT_FSEGS, 0, 0));
        // zero window forces a zero limit
        dir_tab.push_back(mk_row(CMD_ADMIT, 1, 0, 0, 0, 0, 0, 0,
                                 1, VERDICT_FBYTES, 0, 0));
        dir_tab.push_back(mk_row(CMD_ADMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                                 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 63,
                                 1, VERDICT_FBYTES, 0, 0));
        dir_tab.push_back(mk_row(CMD_ADMIT, 5, 0, 1, 10, 2, 0, 1, 0, VERDICT_OK, 0, 0));
        dir_tab.push_back(mk_row(CMD_ADMIT, 6, 0, 1, 10, 2, 0, 1, 0, VERDICT_OK, 0, 0));
        dir_tab.push_back(mk_row(CMD_ADMIT, 5840, 0, 0, 100000, 1, 44160, 0,
                                 0, VERDICT_OK, 0, 0));
        dir_tab.push_back(mk_row(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0,
                                 1, VERDICT_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // saturate on add
        dir_tab.push_back(mk_row(CMD_ADD, 1, 1, 0, 0, 0, 0, 0,
                                 1, VERDICT_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        dir_tab.push_back(mk_row(CMD_ADMIT, 1, 0, 0, 32'hFFFF_FFFF, 1, 0, 0,
                                 1, VERDICT_GBYTES, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // segment total at all ones: the +1 must not wrap
        dir_tab.push_back(mk_row(CMD_ADMIT, 0, 0, 0, 0, 0, 0, 0,
                                 1, VERDICT_GSEGS, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        dir_tab.push_back(mk_row(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                                 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                                 1, VERDICT_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        dir_tab.push_back(mk_row(CMD_REMOVE, 32'h10, 32'h10, 0, 0, 0, 0, 0,
                                 1, VERDICT_OK, 32'hFFFF_FFEF, 32'hFFFF_FFEF));
        // underflow clamps to zero
        dir_tab.push_back(mk_row(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0,
                                 1, VERDICT_OK, 0, 0));
        dir_tab.push_back(mk_row(CMD_REMOVE, 1, 1, 0, 0, 0, 0, 0, 1, VERDICT_OK, 0, 0));
        dir_tab.push_back(mk_row(CMD_ADD, 1048575, 1023, 0, 0, 0, 0, 0,
                                 1, VERDICT_OK, 1048575, 1023));
        dir_tab.push_back(mk_row(CMD_ADMIT, 1, 0, 0, 32'hFFFF_FFFF, 0, 0, 0,
                                 1, VERDICT_OK, 1048575, 1023));
        dir_tab.push_back(mk_row(CMD_ADMIT, 2, 0, 0, 32'hFFFF_FFFF, 0, 0, 0,
                                 1, VERDICT_GBYTES, 1048575, 1023));
        dir_tab.push_back(mk_row(CMD_ADD, 0, 1, 0, 0, 0, 0, 0,
                                 1, VERDICT_OK, 1048575, 1024));
        dir_tab.push_back(mk_row(CMD_ADMIT, 0, 0, 0, 0, 5, 0, 5,
                                 1, VERDICT_GSEGS, 1048575, 1024));
        // fewer nodes than queued: no segment counted
        dir_tab.push_back(mk_row(CMD_ADMIT, 0, 0, 0, 0, 5, 0, 4,
                                 1, VERDICT_OK, 1048575, 1024));
        dir_tab.push_back(mk_row(CMD_ADMIT, 32768, 0, 16'hFFFF, 32'hFFFF_FFFF, 0, 32768, 1,
                                 0, VERDICT_OK, 0, 0));
        dir_tab.push_back(mk_row(CMD_REMOVE, 1048575, 1024, 0, 0, 0, 0, 0,
                                 1, VERDICT_OK, 0, 0));

        load_limits(RST_DEFAULT_MSS, RST_FLOW_MAX_BYTES, RST_FLOW_MAX_SEGS,
                    RST_GLOBAL_MAX_BYTES, RST_GLOBAL_MAX_SEGS);
        foreach (dir_tab[i])
            offer(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
        drain();

        for (p = 1; p <= PHASES; p++)
        begin
            case (p)
                1: load_limits(RST_DEFAULT_MSS, RST_FLOW_MAX_BYTES, RST_FLOW_MAX_SEGS,
                               RST_GLOBAL_MAX_BYTES, RST_GLOBAL_MAX_SEGS);
                2: load_limits(16'd0, 32'd0, 16'd0, 32'd0, 32'd0);
                3: load_limits(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF);
                4: load_limits(16'($urandom_range(1, 1500)), $urandom_range(0, 200000),
                               16'($urandom_range(0, 100)), $urandom_range(0, 4000000),
                               $urandom_range(0, 3000));
                // zero default mss, global limits at or just above the live totals
                5: load_limits(16'd0, $urandom, 16'($urandom_range(0, 16)),
                               acc_bytes + $urandom_range(0, 3000),
                               acc_segs + $urandom_range(0, 5));
                6: load_limits(16'd1, 32'd1, 16'd1, 32'd1, 32'd1);
                default: load_limits(16'($urandom), $urandom, 16'($urandom), $urandom,
                                     $urandom);
            endcase
            case (p % 4)
                0:       begin send_pct = 0;  stall_pct = 0;  end
                1:       begin send_pct = 63; stall_pct = 0;  end
                2:       begin send_pct = 0;  stall_pct = 63; end
                default: begin send_pct = 7;  stall_pct = 7;  end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold while the sender keeps pushing
                if (p == 4 && (n == 20 || n == 100))
                    hold_req++;
                // sender waits for the pipe to empty mid-phase
                if (p == 5 && n == PHASE_ITEMS / 2)
                    drain();
                offer(rand_item(), 1'b0, none);
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/raa_pkg.sv
design/raa_regs.sv
design/raa_admit.sv
design/reassembly_admission_accounting.sv
tb/reassembly_admission_accounting_tb.sv
